>>> src/tdf_pkg.sv
`timescale 1ns / 1ps

package tdf_pkg;

	localparam int VALUE_W    = 32;
	localparam int EXP_W      = 5;
	// width of the value that is factored, even and at most VALUE_W
	localparam int VALUE_BITS = 32;
	// trial divisor can reach 2^(VALUE_BITS/2) before the search ends
	localparam int D_BITS     = VALUE_BITS / 2 + 1;
	localparam int SQ_BITS    = VALUE_BITS + 1;
	// radix-4 restoring divider: two quotient bits a cycle
	localparam int DIV_ITERS  = VALUE_BITS / 2;
	localparam int CNT_BITS   = $clog2(DIV_ITERS);
	localparam int PC_BITS    = 4;

	typedef logic [PC_BITS-1:0] step_t;

	localparam step_t STEP_LOAD    = 4'd0;
	localparam step_t STEP_ONE     = 4'd1;
	localparam step_t STEP_CMP     = 4'd2;
	localparam step_t STEP_ITER    = 4'd3;
	localparam step_t STEP_CHECK   = 4'd4;
	localparam step_t STEP_EMIT    = 4'd5;
	localparam step_t STEP_FIN     = 4'd6;
	localparam step_t STEP_NONE    = 4'd7;
	localparam step_t STEP_RESTART = 4'd8;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIV_START,
		OP_DIV_ITER,
		OP_TAKE,
		OP_EMIT_NEXT,
		OP_EMIT_REST,
		OP_EMIT_NONE
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_REST_LE1,
		COND_SQ_GT,
		COND_REM_ZERO
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// microcode: the step counter stays put while the step stalls,
	// else jumps to target when cond holds, else moves to the next step
	function automatic ctrl_t ucode(input step_t pc);
		ctrl_t w;
		w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_LOAD};
		unique case (pc)
			STEP_LOAD:    w = '{op: OP_LOAD,      cond: COND_NEVER,    target: STEP_LOAD};
			STEP_ONE:     w = '{op: OP_NOP,       cond: COND_REST_LE1, target: STEP_NONE};
			STEP_CMP:     w = '{op: OP_DIV_START, cond: COND_SQ_GT,    target: STEP_FIN};
			STEP_ITER:    w = '{op: OP_DIV_ITER,  cond: COND_NEVER,    target: STEP_LOAD};
			STEP_CHECK:   w = '{op: OP_TAKE,      cond: COND_REM_ZERO, target: STEP_RESTART};
			STEP_EMIT:    w = '{op: OP_EMIT_NEXT, cond: COND_ALWAYS,   target: STEP_CMP};
			STEP_FIN:     w = '{op: OP_EMIT_REST, cond: COND_ALWAYS,   target: STEP_LOAD};
			STEP_NONE:    w = '{op: OP_EMIT_NONE, cond: COND_ALWAYS,   target: STEP_LOAD};
			STEP_RESTART: w = '{op: OP_DIV_START, cond: COND_ALWAYS,   target: STEP_ITER};
			default:      w = '{op: OP_NOP,       cond: COND_ALWAYS,   target: STEP_LOAD};
		endcase
		return w;
	endfunction

endpackage

>>> src/trial_division_factorizer_core.sv
`timescale 1ns / 1ps

// Prime factorizer by trial division.
// Input channel: value with in_valid / in_ready. One value is taken per beat
// and factored completely before the next is taken.
// Output channel: prime, exponent, no_factor, last with out_valid / out_ready.
// Each value yields one beat per distinct prime, ascending, the final beat
// with last set. A value of 0 or 1 yields a single beat with no_factor set.
// A small microcode table steps a shared datapath. Each trial divisor
// passes compare and divider start, a radix-4 divider, check and emit;
// each extra time a divisor goes in repeats divider start, divider and check.
// The divisor loop and its divider set the search time: a prime near 2^32
// tries every divisor below 2^16, a value of 1 goes straight to its beat.
// A result sits in an output register; while it waits the search goes on
// and only stalls at the next result. A stalled receiver thus holds the
// sequencer only at its emit steps.
// Reset clears the step counter and the output valid; the block is then
// ready for a value.
module trial_division_factorizer_core import tdf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VALUE_W-1:0] prime,
	output logic [EXP_W-1:0]   exponent,
	output logic               no_factor,
	output logic               last
);

	step_t                 pc_q;
	ctrl_t                 cw;
	logic [VALUE_BITS-1:0] rest_q;
	logic [D_BITS-1:0]     d_q;
	logic [SQ_BITS-1:0]    sq_q;
	logic [EXP_W-1:0]      mult_q;
	logic [D_BITS-1:0]     rem_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [CNT_BITS-1:0]   cnt_q;

	logic                  out_valid_q;
	logic [VALUE_W-1:0]    prime_q;
	logic [EXP_W-1:0]      exponent_q;
	logic                  no_factor_q;
	logic                  last_q;

	logic                  out_free;
	logic                  emit_want;
	logic                  emit_fire;
	logic                  div_last;
	logic                  stall;
	logic                  cond_true;
	step_t                 pc_next;

	logic [D_BITS:0]       div_t1;
	logic [D_BITS:0]       div_t2;
	logic                  div_ge1;
	logic                  div_ge2;
	logic [D_BITS-1:0]     div_r1;
	logic [D_BITS-1:0]     div_r2;

	assign cw       = ucode(pc_q);
	assign out_free = !out_valid_q || out_ready;
	assign div_last = (cnt_q == CNT_BITS'(DIV_ITERS - 1));

	always_comb begin
		unique case (cw.op)
			OP_EMIT_NEXT: emit_want = (mult_q != '0);
			OP_EMIT_REST: emit_want = (rest_q != VALUE_BITS'(1));
			OP_EMIT_NONE: emit_want = 1'b1;
			default:      emit_want = 1'b0;
		endcase
	end

	assign emit_fire = emit_want && out_free;
	assign stall = ((cw.op == OP_LOAD) && !in_valid) ||
	               ((cw.op == OP_DIV_ITER) && !div_last) ||
	               (emit_want && !out_free);

	always_comb begin
		unique case (cw.cond)
			COND_NEVER:    cond_true = 1'b0;
			COND_ALWAYS:   cond_true = 1'b1;
			COND_REST_LE1: cond_true = (rest_q <= VALUE_BITS'(1));
			COND_SQ_GT:    cond_true = (sq_q > SQ_BITS'(rest_q));
			COND_REM_ZERO: cond_true = (rem_q == '0);
			default:       cond_true = 1'b0;
		endcase
	end

	always_comb begin
		priority if (stall) begin
			pc_next = pc_q;
		end else if (cond_true) begin
			pc_next = cw.target;
		end else begin
			pc_next = pc_q + step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_LOAD;
		end else begin
			pc_q <= pc_next;
		end
	end

	// two restoring steps per cycle, remainder always stays below the divisor
	always_comb begin
		div_t1  = {rem_q, quo_q[VALUE_BITS-1]};
		div_ge1 = (div_t1 >= {1'b0, d_q});
		div_r1  = div_ge1 ? D_BITS'(div_t1 - {1'b0, d_q}) : D_BITS'(div_t1);
		div_t2  = {div_r1, quo_q[VALUE_BITS-2]};
		div_ge2 = (div_t2 >= {1'b0, d_q});
		div_r2  = div_ge2 ? D_BITS'(div_t2 - {1'b0, d_q}) : D_BITS'(div_t2);
	end

	always_ff @(posedge clk) begin
		unique case (cw.op)
			OP_LOAD: begin
				if (in_valid) begin
					rest_q <= value[VALUE_BITS-1:0];
					d_q    <= D_BITS'(2);
					sq_q   <= SQ_BITS'(4);
					mult_q <= '0;
				end
			end
			OP_DIV_START: begin
				rem_q <= '0;
				quo_q <= rest_q;
				cnt_q <= '0;
			end
			OP_DIV_ITER: begin
				rem_q <= div_r2;
				quo_q <= {quo_q[VALUE_BITS-3:0], div_ge1, div_ge2};
				cnt_q <= cnt_q + CNT_BITS'(1);
			end
			OP_TAKE: begin
				if (rem_q == '0) begin
					rest_q <= quo_q;
					mult_q <= mult_q + EXP_W'(1);
				end
			end
			OP_EMIT_NEXT: begin
				if (!stall) begin
					// (d+1)^2 = d^2 + 2d + 1
					d_q    <= d_q + D_BITS'(1);
					sq_q   <= sq_q + SQ_BITS'({d_q, 1'b1});
					mult_q <= '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// a pair is final exactly when nothing is left to factor
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			unique case (cw.op)
				OP_EMIT_NEXT: begin
					prime_q     <= VALUE_W'(d_q);
					exponent_q  <= mult_q;
					no_factor_q <= 1'b0;
					last_q      <= (rest_q == VALUE_BITS'(1));
				end
				OP_EMIT_REST: begin
					prime_q     <= VALUE_W'(rest_q);
					exponent_q  <= EXP_W'(1);
					no_factor_q <= 1'b0;
					last_q      <= 1'b1;
				end
				OP_EMIT_NONE: begin
					prime_q     <= '0;
					exponent_q  <= '0;
					no_factor_q <= 1'b1;
					last_q      <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign in_ready  = (cw.op == OP_LOAD);
	assign out_valid = out_valid_q;
	assign prime     = prime_q;
	assign exponent  = exponent_q;
	assign no_factor = no_factor_q;
	assign last      = last_q;

endmodule

>>> src/tdf_checker.sv
`timescale 1ns / 1ps

module tdf_checker import tdf_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [VALUE_W-1:0] prime,
	input logic [EXP_W-1:0]   exponent,
	input logic               no_factor,
	input logic               last
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prime) && $stable(exponent)
		&& $stable(no_factor) && $stable(last))
		else $error("output beat changed while stalled");

	// one value at a time: busy right after taking a beat
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again before the value was factored");

	a_no_factor_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_factor |-> last && (prime == '0) && (exponent == '0))
		else $error("malformed no-factor beat");

	a_factor_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !no_factor |-> (exponent != '0) && (prime > VALUE_W'(1)))
		else $error("factor beat with bad prime or exponent");

endmodule

bind trial_division_factorizer_core tdf_checker u_tdf_checker (.*);

>>> bench/tb_trial_division_factorizer_core.sv
`timescale 1ns / 1ps

module tb_trial_division_factorizer_core;
	import tdf_pkg::*;

	typedef struct packed {
		logic [VALUE_W-1:0] prime;
		logic [EXP_W-1:0]   exponent;
		logic               no_factor;
		logic               last;
	} factor_beat_t;

	// typed rows carry a single-beat answer, the rest go through the predictor
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               typed;
		factor_beat_t       beat;
	} directed_row_t;

	localparam int N_DIRECTED = 22;
	localparam int N_RANDOM   = 78;

	localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{32'd0,          1'b1, '{32'd0, 5'd0,  1'b1, 1'b1}},
		'{32'd1,          1'b1, '{32'd0, 5'd0,  1'b1, 1'b1}},
		'{32'd2,          1'b1, '{32'd2, 5'd1,  1'b0, 1'b1}},
		'{32'd3,          1'b1, '{32'd3, 5'd1,  1'b0, 1'b1}},
		'{32'd4,          1'b1, '{32'd2, 5'd2,  1'b0, 1'b1}},
		'{32'h8000_0000,  1'b1, '{32'd2, 5'd31, 1'b0, 1'b1}},
		'{32'h0001_0000,  1'b1, '{32'd2, 5'd16, 1'b0, 1'b1}},
		'{32'hFFFF_FFFF,  1'b0, '0},
		'{32'hFFFF_FFFE,  1'b0, '0},
		'{32'hAAAA_AAAA,  1'b0, '0},
		'{32'h5555_5555,  1'b0, '0},
		'{32'd6,          1'b0, '0},
		'{32'd9,          1'b0, '0},
		'{32'd12,         1'b0, '0},
		'{32'd25,         1'b0, '0},
		'{32'd97,         1'b0, '0},
		'{32'd65537,      1'b0, '0},
		'{32'd223092870,  1'b0, '0},
		'{32'd446185740,  1'b0, '0},
		'{32'd3486784401, 1'b0, '0},
		'{32'd4294836225, 1'b0, '0},
		'{32'd1000003,    1'b0, '0}
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [VALUE_W-1:0] value;
	logic               out_valid;
	logic               out_ready;
	logic [VALUE_W-1:0] prime;
	logic [EXP_W-1:0]   exponent;
	logic               no_factor;
	logic               last;

	factor_beat_t expected_factors [$];
	int           values_sent;
	int           beats_checked;
	int           mismatches;
	bit           no_idle;

	trial_division_factorizer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.prime     (prime),
		.exponent  (exponent),
		.no_factor (no_factor),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(100_000_000);
		$display("** trial_division_factorizer_core: FAILED **");
		$finish;
	end

	// trial division on the masked value, one beat per distinct prime, or a no-factor beat for 0 or 1
	function automatic void predict_factors(input logic [VALUE_W-1:0] v);
		longint unsigned rest;
		longint unsigned d;
		int              mult;
		int              n;
		factor_beat_t    beats [10];
		rest = (VALUE_BITS >= 32) ? v : (v & ((64'd1 << VALUE_BITS) - 1));
		n = 0;
		if (rest <= 1) begin
			expected_factors.push_back('{32'd0, 5'd0, 1'b1, 1'b1});
			return;
		end
		for (d = 2; d * d <= rest; d++) begin
			mult = 0;
			while (rest % d == 0) begin
				rest = rest / d;
				mult++;
			end
			if (mult > 0) begin
				beats[n] = '{d[VALUE_W-1:0], mult[EXP_W-1:0], 1'b0, 1'b0};
				n++;
			end
		end
		if (rest != 1) begin
			beats[n] = '{rest[VALUE_W-1:0], 5'd1, 1'b0, 1'b0};
			n++;
		end
		beats[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_factors.push_back(beats[i]);
	endfunction

	// mostly values whose search stays short: smooth products, shifted
	// 16-bit values, a few up to 2^20, and the odd zero or one
	function automatic logic [VALUE_W-1:0] pick_value();
		longint unsigned prod;
		longint unsigned f;
		int              kind;
		int              n;
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			prod = 1;
			n = $urandom_range(1, 8);
			repeat (n) begin
				f = $urandom_range(2, 300);
				if (prod * f <= 64'hFFFF_FFFF)
					prod = prod * f;
			end
			return prod[VALUE_W-1:0];
		end else if (kind < 80) begin
			prod = longint'($urandom_range(1, 65535)) << $urandom_range(0, 16);
			return prod[VALUE_W-1:0];
		end else if (kind < 95) begin
			return $urandom_range(2, 1 << 20);
		end else begin
			return $urandom_range(0, 1);
		end
	endfunction

	task automatic send_value(input logic [VALUE_W-1:0] v);
		while (!no_idle && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		values_sent++;
	endtask

	// receiver: check each accepted beat, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			beats_checked++;
			if (expected_factors.size() == 0) begin
				$error("unexpected beat: prime %0d exponent %0d no_factor %0d last %0d",
					prime, exponent, no_factor, last);
				mismatches++;
			end else begin
				factor_beat_t want;
				want = expected_factors.pop_front();
				if (prime !== want.prime) begin
					$error("prime: expected %0d, got %0d", want.prime, prime);
					mismatches++;
				end
				if (exponent !== want.exponent) begin
					$error("exponent: expected %0d, got %0d", want.exponent, exponent);
					mismatches++;
				end
				if (no_factor !== want.no_factor) begin
					$error("no_factor: expected %0d, got %0d", want.no_factor, no_factor);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					mismatches++;
				end
			end
		end
		out_ready <= no_idle || ($urandom_range(0, 99) >= 17);
	end

	initial begin
		values_sent   = 0;
		beats_checked = 0;
		mismatches    = 0;
		no_idle       = 1'b0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		value     <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_value(DIRECTED_ROWS[i].value);
			if (DIRECTED_ROWS[i].typed)
				expected_factors.push_back(DIRECTED_ROWS[i].beat);
			else
				predict_factors(DIRECTED_ROWS[i].value);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			logic [VALUE_W-1:0] v;
			// a stretch with both sides at full rate
			no_idle = (i >= 35 && i < 65);
			v = pick_value();
			send_value(v);
			predict_factors(v);
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;

		while (expected_factors.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("factored %0d values (%0d directed, %0d random), %0d result beats checked",
			values_sent, N_DIRECTED, N_RANDOM, beats_checked);
		if (mismatches == 0) begin
			$display("** trial_division_factorizer_core: PASSED **");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("** trial_division_factorizer_core: FAILED **");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/tdf_pkg.sv
src/trial_division_factorizer_core.sv
src/tdf_checker.sv
bench/tb_trial_division_factorizer_core.sv
